### hw/rtl/zncc_image_similarity_core_assert.svh
// ----------------------------------------------------------------------------
// ZNCC assertion macros
// Shared concurrent assertion forms for the zncc checker.
// ----------------------------------------------------------------------------
`ifndef ZNCC_IMAGE_SIMILARITY_CORE_ASSERT_SVH
`define ZNCC_IMAGE_SIMILARITY_CORE_ASSERT_SVH

// same-cycle implication
`define ZNCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zncc assertion failed");

// next-cycle implication
`define ZNCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zncc assertion failed");

`endif

### hw/rtl/zncc_pkg.sv
// ----------------------------------------------------------------------------
// ZNCC package
// Sequencer states and fixed widths of the score search.
// ----------------------------------------------------------------------------
package zncc_pkg;

  localparam int PIX_W    = 8;
  localparam int CORR_W   = 16;
  localparam int ODD_W    = CORR_W + 1;
  localparam int ODD2_W   = 2 * ODD_W;
  localparam int RHS_SHIFT = 32;
  localparam int K_W      = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VAL,
    ST_VAR,
    ST_VBL,
    ST_VBR,
    ST_SAB,
    ST_PAB,
    ST_VPROD,
    ST_M2,
    ST_ODD2,
    ST_LHS,
    ST_DONE
  } zncc_state_t;

endpackage

### hw/rtl/zncc_mul.sv
// ----------------------------------------------------------------------------
// ZNCC shift-add multiplier
// Shared unsigned multiplier, one multiplier bit per cycle, stops early.
// ----------------------------------------------------------------------------
module zncc_mul #(
  parameter int W = 134
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] product
);

  logic [W-1:0] xa;
  logic [W-1:0] yb;
  logic [W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      yb <= '0;
    end else if (start) begin
      yb <= b;
    end else if (yb != '0) begin
      yb <= yb >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xa  <= a;
      acc <= '0;
    end else if (yb != '0) begin
      if (yb[0]) begin
        acc <= acc + xa;
      end
      xa <= xa << 1;
    end
  end

  assign done    = (yb == '0);
  assign product = acc;

endmodule

### hw/rtl/zncc_image_similarity_core.sv
// ----------------------------------------------------------------------------
// ZNCC image similarity core
// Zero-mean normalized cross-correlation of two 8-bit pixel streams.
// ----------------------------------------------------------------------------
// Input: pixel pairs on s_*, s_tdata = {pixel_b, pixel_a}, s_tlast marks the
// final pair of an image. Non-final pairs are taken one per cycle and added
// to running sums. After the final pair, s_tready drops while one shared
// shift-add multiplier runs the score: six moment products, the energy
// product, the squared numerator, then a 16-step bitwise search of the
// rounded Q1.15 score with two products per step. Each product lasts longer
// the more significant bits its multiplier operand has (up to 50), and a
// constant image is flagged degenerate and skips the rest of the score.
// A result lands in an output register on m_*: m_tdata = correlation,
// m_tuser = {overflow, degenerate}. While the receiver stalls, the result
// holds and the core waits before clearing its sums and taking new pixels.
// Pairs beyond PIXEL_CAPACITY are dropped and flag overflow.
// Reset clears the sums, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module zncc_image_similarity_core
  import zncc_pkg::*;
#(
  parameter int PIXEL_CAPACITY = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] pixel_a, [15:8] pixel_b
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] correlation
  output logic [1:0]  m_tuser    // [0] degenerate, [1] overflow
);

  localparam int CW = $clog2(PIXEL_CAPACITY + 1);
  localparam int SW = CW + PIX_W;
  localparam int QW = CW + 2 * PIX_W;
  localparam int VW = 2 * CW + 2 * PIX_W;
  localparam int PW = 2 * VW;
  localparam int MW = PW + ODD2_W;

  zncc_state_t state, state_next;

  logic [CW-1:0] pixel_count;
  logic [SW-1:0] sum_first, sum_second;
  logic [QW-1:0] sum_first_squared, sum_second_squared, sum_cross_product;
  logic          overflow_seen;

  logic [VW-1:0]     tmp, va, vb, mag;
  logic              neg, degen, issued;
  logic [PW-1:0]     vprod;
  logic [MW-1:0]     rhs;
  logic [CORR_W-1:0] q, cand;
  logic [K_W-1:0]    k;
  logic [ODD_W-1:0]  odd;
  logic [ODD2_W-1:0] o2;

  logic          mul_start, mul_done, step_done, out_free, s_fire;
  logic [MW-1:0] mul_a, mul_b, prod;
  logic [VW-1:0] prod_v;
  logic [15:0]   corr_value;
  logic [PIX_W-1:0] pa, pb;

  assign pa        = s_tdata[PIX_W-1:0];
  assign pb        = s_tdata[2*PIX_W-1:PIX_W];
  assign s_tready  = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign step_done = issued && mul_done;
  assign prod_v    = prod[VW-1:0];
  assign cand      = q | (CORR_W'(1) << k);
  assign odd       = {cand, 1'b0} - ODD_W'(1);

  zncc_mul #(.W(MW)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (prod)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_VAL:   begin mul_a = MW'(pixel_count); mul_b = MW'(sum_first_squared); end
      ST_VAR:   begin mul_a = MW'(sum_first);   mul_b = MW'(sum_first);         end
      ST_VBL:   begin mul_a = MW'(pixel_count); mul_b = MW'(sum_second_squared); end
      ST_VBR:   begin mul_a = MW'(sum_second);  mul_b = MW'(sum_second);        end
      ST_SAB:   begin mul_a = MW'(pixel_count); mul_b = MW'(sum_cross_product); end
      ST_PAB:   begin mul_a = MW'(sum_first);   mul_b = MW'(sum_second);        end
      ST_VPROD: begin mul_a = MW'(va);          mul_b = MW'(vb);                end
      ST_M2:    begin mul_a = MW'(mag);         mul_b = MW'(mag);               end
      ST_ODD2:  begin mul_a = MW'(odd);         mul_b = MW'(odd);               end
      ST_LHS:   begin mul_a = MW'(vprod);       mul_b = MW'(o2);                end
      default:  begin mul_a = '0;               mul_b = '0;                     end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_fire && s_tlast) begin
          state_next = ST_VAL;
        end
      end
      ST_VAL, ST_VBL, ST_SAB, ST_PAB, ST_VPROD, ST_M2, ST_ODD2: begin
        mul_start = !issued;
        if (step_done) begin
          unique case (state)
            ST_VAL:   state_next = ST_VAR;
            ST_VBL:   state_next = ST_VBR;
            ST_SAB:   state_next = ST_PAB;
            ST_PAB:   state_next = ST_VPROD;
            ST_VPROD: state_next = ST_M2;
            ST_M2:    state_next = ST_ODD2;
            default:  state_next = ST_LHS;
          endcase
        end
      end
      ST_VAR: begin
        mul_start = !issued;
        if (step_done) begin
          state_next = (tmp <= prod_v) ? ST_DONE : ST_VBL;
        end
      end
      ST_VBR: begin
        mul_start = !issued;
        if (step_done) begin
          state_next = (tmp <= prod_v) ? ST_DONE : ST_SAB;
        end
      end
      ST_LHS: begin
        mul_start = !issued;
        if (step_done) begin
          state_next = (k == '0) ? ST_DONE : ST_ODD2;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issued <= 1'b0;
    end else if (mul_start) begin
      issued <= 1'b1;
    end else if (step_done) begin
      issued <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_done) begin
      case (state)
        ST_VAL, ST_VBL, ST_SAB: tmp <= prod_v;
        ST_VAR: begin
          va    <= tmp - prod_v;
          degen <= (tmp <= prod_v);
        end
        ST_VBR: begin
          vb    <= tmp - prod_v;
          degen <= (tmp <= prod_v);
        end
        ST_PAB: begin
          neg <= (tmp < prod_v);
          mag <= (tmp < prod_v) ? (prod_v - tmp) : (tmp - prod_v);
        end
        ST_VPROD: vprod <= prod[PW-1:0];
        ST_M2: begin
          rhs <= prod << RHS_SHIFT;
          q   <= '0;
          k   <= K_W'(CORR_W - 1);
        end
        ST_ODD2: o2 <= prod[ODD2_W-1:0];
        ST_LHS: begin
          if (prod <= rhs) begin
            q <= cand;
          end
          k <= k - K_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (state == ST_DONE && out_free)) begin
      pixel_count        <= '0;
      sum_first          <= '0;
      sum_second         <= '0;
      sum_first_squared  <= '0;
      sum_second_squared <= '0;
      sum_cross_product  <= '0;
      overflow_seen      <= 1'b0;
    end else if (s_fire) begin
      if (pixel_count == CW'(PIXEL_CAPACITY)) begin
        overflow_seen <= 1'b1;
      end else begin
        pixel_count        <= pixel_count + CW'(1);
        sum_first          <= sum_first + SW'(pa);
        sum_second         <= sum_second + SW'(pb);
        sum_first_squared  <= sum_first_squared + QW'(pa) * QW'(pa);
        sum_second_squared <= sum_second_squared + QW'(pb) * QW'(pb);
        sum_cross_product  <= sum_cross_product + QW'(pa) * QW'(pb);
      end
    end
  end

  always_comb begin
    if (degen) begin
      corr_value = '0;
    end else if (neg) begin
      corr_value = '0 - q;
    end else begin
      corr_value = q[CORR_W-1] ? 16'h7FFF : q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= corr_value;
      m_tuser <= {overflow_seen, degen};
    end
  end

endmodule

### hw/rtl/zncc_sva.sv
// ----------------------------------------------------------------------------
// ZNCC port checker
// Port-level assertions for the zncc core, bound to the top level.
// ----------------------------------------------------------------------------
`include "zncc_image_similarity_core_assert.svh"

module zncc_sva (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);

  `ZNCC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `ZNCC_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready)
  `ZNCC_ASSERT_NOW(a_degen_zero, m_tvalid && m_tuser[0], m_tdata == 16'h0000)
  `ZNCC_ASSERT_NOW(a_result_from_busy, $rose(m_tvalid), !$past(s_tready))

endmodule

bind zncc_image_similarity_core zncc_sva u_zncc_sva (.*);
